// ===== rtl/pulse_width_period_duty_capture_unit_assert.svh =====
// Assertion macros for the capture unit.
`ifndef PULSE_WIDTH_PERIOD_DUTY_CAPTURE_UNIT_ASSERT_SVH
`define PULSE_WIDTH_PERIOD_DUTY_CAPTURE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PWPDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PWPDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pwpdc_pkg.sv =====
package pwpdc_pkg;

    localparam int STAMP_W    = 16;
    localparam int DUTY_W     = 7;
    localparam int DIVIDEND_W = STAMP_W + DUTY_W;
    localparam int STEP_W     = 3;

    localparam logic [DUTY_W-1:0] FULL_DUTY = 7'd100;
    localparam logic [STEP_W-1:0] QUO_STEPS = 3'd7;

    // capture phase codes; the unused code behaves as PH_START
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_LOAD  = 4'b1000
    } state_t;

    typedef struct packed {
        logic              busy;
        logic [DUTY_W-1:0] quotient;
    } div_sts_t;

endpackage

// ===== rtl/pwpdc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Needs quotient < 2**DUTY_W, i.e. dividend[22:7] < divisor.
module pwpdc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pwpdc_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [pwpdc_pkg::STAMP_W-1:0]       divisor,
    output pwpdc_pkg::div_sts_t                 sts
);

    logic [pwpdc_pkg::STEP_W-1:0]  cnt_reg;
    logic [pwpdc_pkg::STEP_W-1:0]  cnt_next;
    logic [pwpdc_pkg::STAMP_W-1:0] rem_reg;
    logic [pwpdc_pkg::STAMP_W-1:0] rem_next;
    logic [pwpdc_pkg::DUTY_W-1:0]  dvd_reg;
    logic [pwpdc_pkg::DUTY_W-1:0]  dvd_next;
    logic [pwpdc_pkg::DUTY_W-1:0]  quo_reg;
    logic [pwpdc_pkg::DUTY_W-1:0]  quo_next;
    logic [pwpdc_pkg::STAMP_W:0]   trial;
    logic [pwpdc_pkg::STAMP_W:0]   diff;
    logic                          ge;

    assign trial = {rem_reg, dvd_reg[pwpdc_pkg::DUTY_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = ge ? diff[pwpdc_pkg::STAMP_W-1:0] : trial[pwpdc_pkg::STAMP_W-1:0];
            dvd_next = {dvd_reg[pwpdc_pkg::DUTY_W-2:0], 1'b0};
            quo_next = {quo_reg[pwpdc_pkg::DUTY_W-2:0], ge};
        end
        else if (start)
        begin
            cnt_next = pwpdc_pkg::QUO_STEPS;
            rem_next = dividend[pwpdc_pkg::DIVIDEND_W-1:pwpdc_pkg::DUTY_W];
            dvd_next = dividend[pwpdc_pkg::DUTY_W-1:0];
            quo_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign sts.busy     = (cnt_reg != '0);
    assign sts.quotient = quo_reg;

endmodule

// ===== rtl/pulse_width_period_duty_capture_unit.sv =====
// Input capture for pulse width, period and duty. Each request is one edge
// event: its polarity and a 16-bit free-running timer stamp. The unit keeps
// the stamp of a rising edge, then of the next falling edge, and on the next
// rising edge issues one result: high width and period (modulo 2^16
// differences) and duty = floor(100*width/period). A zero period or a width
// beyond the period gives duty 100 with range_error set. Edges of the wrong
// polarity are taken and dropped. Opening and falling edges only store their
// stamp. A closing edge passes through accept, range check, seven divider
// steps, quotient pick-up and result load, skipping the divider steps when
// the range check fails; the bit-serial divider retires one quotient bit per
// cycle. A finished result sits in an output register, so further edges are
// taken while it waits; only a second result stalls until the first is taken.
module pulse_width_period_duty_capture_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                edge_rising,
    input  logic [pwpdc_pkg::STAMP_W-1:0]       capture_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pwpdc_pkg::STAMP_W-1:0]       high_width,
    output logic [pwpdc_pkg::STAMP_W-1:0]       full_period,
    output logic [pwpdc_pkg::DUTY_W-1:0]        duty_percent,
    output logic                                range_error
);

    pwpdc_pkg::state_t state_reg;
    pwpdc_pkg::state_t state_next;

    logic [1:0]                         phase_reg;
    logic [1:0]                         phase_next;
    logic [pwpdc_pkg::STAMP_W-1:0]      start_reg;
    logic [pwpdc_pkg::STAMP_W-1:0]      start_next;
    logic [pwpdc_pkg::STAMP_W-1:0]      fall_reg;
    logic [pwpdc_pkg::STAMP_W-1:0]      fall_next;
    logic [pwpdc_pkg::STAMP_W-1:0]      width_reg;
    logic [pwpdc_pkg::STAMP_W-1:0]      width_next;
    logic [pwpdc_pkg::STAMP_W-1:0]      period_reg;
    logic [pwpdc_pkg::STAMP_W-1:0]      period_next;
    logic [pwpdc_pkg::DUTY_W-1:0]       duty_reg;
    logic [pwpdc_pkg::DUTY_W-1:0]       duty_next;
    logic                               err_reg;
    logic                               err_next;

    // output register
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [pwpdc_pkg::STAMP_W-1:0]      ow_reg;
    logic [pwpdc_pkg::STAMP_W-1:0]      ow_next;
    logic [pwpdc_pkg::STAMP_W-1:0]      op_reg;
    logic [pwpdc_pkg::STAMP_W-1:0]      op_next;
    logic [pwpdc_pkg::DUTY_W-1:0]       od_reg;
    logic [pwpdc_pkg::DUTY_W-1:0]       od_next;
    logic                               oe_reg;
    logic                               oe_next;

    logic                               div_start;
    logic [pwpdc_pkg::DIVIDEND_W-1:0]   dividend;
    logic [pwpdc_pkg::DIVIDEND_W-1:0]   width_ext;
    pwpdc_pkg::div_sts_t                div_sts;

    // 100*w = 64w + 32w + 4w
    assign width_ext = {{(pwpdc_pkg::DIVIDEND_W-pwpdc_pkg::STAMP_W){1'b0}}, width_reg};
    assign dividend  = (width_ext << 6) + (width_ext << 5) + (width_ext << 2);

    pwpdc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (period_reg),
        .sts      (div_sts)
    );

    assign in_ready = (state_reg == pwpdc_pkg::S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        fall_next      = fall_reg;
        width_next     = width_reg;
        period_next    = period_reg;
        duty_next      = duty_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        ow_next        = ow_reg;
        op_next        = op_reg;
        od_next        = od_reg;
        oe_next        = oe_reg;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pwpdc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (phase_reg)
                        pwpdc_pkg::PH_FALL:
                        begin
                            if (!edge_rising)
                            begin
                                fall_next  = capture_time;
                                phase_next = pwpdc_pkg::PH_CLOSE;
                            end
                        end
                        pwpdc_pkg::PH_CLOSE:
                        begin
                            if (edge_rising)
                            begin
                                width_next  = fall_reg - start_reg;
                                period_next = capture_time - start_reg;
                                phase_next  = pwpdc_pkg::PH_START;
                                state_next  = pwpdc_pkg::S_CHECK;
                            end
                        end
                        default:
                        begin
                            // awaiting opening edge (unused code too)
                            if (edge_rising)
                            begin
                                start_next = capture_time;
                                phase_next = pwpdc_pkg::PH_FALL;
                            end
                        end
                    endcase
                end
            end
            pwpdc_pkg::S_CHECK:
            begin
                if ((period_reg == '0) || (width_reg > period_reg))
                begin
                    duty_next  = pwpdc_pkg::FULL_DUTY;
                    err_next   = 1'b1;
                    state_next = pwpdc_pkg::S_LOAD;
                end
                else
                begin
                    div_start  = 1'b1;
                    err_next   = 1'b0;
                    state_next = pwpdc_pkg::S_DIV;
                end
            end
            pwpdc_pkg::S_DIV:
            begin
                if (!div_sts.busy)
                begin
                    duty_next  = div_sts.quotient;
                    state_next = pwpdc_pkg::S_LOAD;
                end
            end
            pwpdc_pkg::S_LOAD:
            begin
                // wait for a free output slot
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ow_next        = width_reg;
                    op_next        = period_reg;
                    od_next        = duty_reg;
                    oe_next        = err_reg;
                    state_next     = pwpdc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pwpdc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwpdc_pkg::S_IDLE;
            phase_reg     <= pwpdc_pkg::PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        fall_reg   <= fall_next;
        width_reg  <= width_next;
        period_reg <= period_next;
        duty_reg   <= duty_next;
        err_reg    <= err_next;
        ow_reg     <= ow_next;
        op_reg     <= op_next;
        od_reg     <= od_next;
        oe_reg     <= oe_next;
    end

    assign out_valid    = out_valid_reg;
    assign high_width   = ow_reg;
    assign full_period  = op_reg;
    assign duty_percent = od_reg;
    assign range_error  = oe_reg;

`include "pulse_width_period_duty_capture_unit_assert.svh"

    // closing edge always leads to the range check
    `PWPDC_ASSERT_NEXT(a_close_to_check, clk, rst_n,
        in_valid && in_ready && edge_rising && (phase_reg == pwpdc_pkg::PH_CLOSE),
        state_reg == pwpdc_pkg::S_CHECK, "closing edge did not start range check")

    // a free slot in the load state produces a result
    `PWPDC_ASSERT_NEXT(a_load_issues, clk, rst_n,
        (state_reg == pwpdc_pkg::S_LOAD) && (!out_valid_reg || out_ready),
        out_valid && (state_reg == pwpdc_pkg::S_IDLE), "result not issued")

    // error results saturate
    `PWPDC_ASSERT_NOW(a_err_sat, clk, rst_n, out_valid && range_error,
        duty_percent == pwpdc_pkg::FULL_DUTY, "error result not saturated")

    // in-range results are consistent
    `PWPDC_ASSERT_NOW(a_in_range, clk, rst_n, out_valid && !range_error,
        (duty_percent <= pwpdc_pkg::FULL_DUTY) && (high_width <= full_period)
        && (full_period != '0), "in-range result inconsistent")

endmodule

// ===== dv/tb_pulse_width_period_duty_capture_unit.sv =====
module tb_pulse_width_period_duty_capture_unit;

    localparam int STAMP_W = pwpdc_pkg::STAMP_W;
    localparam int DUTY_W  = pwpdc_pkg::DUTY_W;

    // Watchdog limit: cycles in a row with no request taken on either side.
    // The longest quiet stretch in a correct run is the long receiver hold
    // (HOLD_CYCLES) plus a closing measurement, so this leaves ample margin.
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 31;

    // One edge event as offered to the unit
    typedef struct packed {
        logic               rising;
        logic [STAMP_W-1:0] stamp;
    } edge_req_t;

    // One measurement as issued by the unit
    typedef struct packed {
        logic [STAMP_W-1:0] width;
        logic [STAMP_W-1:0] period;
        logic [DUTY_W-1:0]  duty;
        logic               err;
    } pulse_meas_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               edge_rising  = 1'b0;
    logic [STAMP_W-1:0] capture_time = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [STAMP_W-1:0] high_width;
    logic [STAMP_W-1:0] full_period;
    logic [DUTY_W-1:0]  duty_percent;
    logic               range_error;

    // Edge events still to be offered, and measurements still owed
    edge_req_t   edge_q[$];
    pulse_meas_t meas_q[$];

    // Local copy of the capture sequencer
    logic [1:0]         cap_phase;
    logic [STAMP_W-1:0] cap_start;
    logic [STAMP_W-1:0] cap_fall;

    int        err_count = 0;
    int        quiet_cycles = 0;
    bit        req_taken = 1'b0;   // set at the edge a request is taken
    bit        no_idle = 1'b0;     // both sides run flat out while set
    bit        long_hold_req = 1'b0;
    bit        long_hold_done = 1'b0;
    int        hold_left = 0;
    edge_req_t next_req;

    pulse_width_period_duty_capture_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .edge_rising  (edge_rising),
        .capture_time (capture_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .high_width   (high_width),
        .full_period  (full_period),
        .duty_percent (duty_percent),
        .range_error  (range_error)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Advance the sequencer by one taken edge; a closing rising edge owes
    // one measurement.
    task automatic track_edge(input edge_req_t r);
        logic [STAMP_W-1:0] w;
        logic [STAMP_W-1:0] p;
        pulse_meas_t        m;
        begin
            case (cap_phase)
                pwpdc_pkg::PH_FALL:
                begin
                    if (!r.rising)
                    begin
                        cap_fall  = r.stamp;
                        cap_phase = pwpdc_pkg::PH_CLOSE;
                    end
                end
                pwpdc_pkg::PH_CLOSE:
                begin
                    if (r.rising)
                    begin
                        w = cap_fall - cap_start;
                        p = r.stamp - cap_start;
                        m.width  = w;
                        m.period = p;
                        if (p == '0 || w > p)
                        begin
                            m.duty = pwpdc_pkg::FULL_DUTY;
                            m.err  = 1'b1;
                        end
                        else
                        begin
                            m.duty = DUTY_W'((32'd100 * 32'(w)) / 32'(p));
                            m.err  = 1'b0;
                        end
                        meas_q.push_back(m);
                        cap_phase = pwpdc_pkg::PH_START;
                    end
                end
                default:
                begin
                    // opening edge; the unused phase code behaves the same
                    if (r.rising)
                    begin
                        cap_start = r.stamp;
                        cap_phase = pwpdc_pkg::PH_FALL;
                    end
                end
            endcase
        end
    endtask

    task automatic add_edge(input logic rising, input logic [STAMP_W-1:0] stamp);
        edge_req_t r;
        begin
            r.rising = rising;
            r.stamp  = stamp;
            edge_q.push_back(r);
        end
    endtask

    // One full rising/falling/rising sequence with random content and an
    // occasional wrong-polarity edge slipped in at each phase.
    task automatic add_random_cycle();
        logic [STAMP_W-1:0] t0;
        logic [STAMP_W-1:0] w;
        logic [STAMP_W-1:0] p;
        int                 kind;
        begin
            t0   = STAMP_W'($urandom);
            kind = $urandom_range(0, 9);
            case (kind)
                0:
                begin
                    // width beyond period
                    p = STAMP_W'($urandom_range(0, 65534));
                    w = p + STAMP_W'($urandom_range(1, 65535 - int'(p)));
                end
                1:
                begin
                    p = STAMP_W'($urandom);
                    w = p;
                end
                2:
                begin
                    p = '0;
                    w = STAMP_W'($urandom_range(0, 3));
                end
                3:
                begin
                    w = STAMP_W'($urandom);
                    p = STAMP_W'($urandom);
                end
                4, 5:
                begin
                    p = STAMP_W'($urandom_range(1, 200));
                    w = STAMP_W'($urandom_range(0, int'(p)));
                end
                default:
                begin
                    p = STAMP_W'($urandom_range(1, 65535));
                    w = STAMP_W'($urandom_range(0, int'(p)));
                end
            endcase
            if ($urandom_range(0, 99) < 15)
                add_edge(1'b0, STAMP_W'($urandom));
            add_edge(1'b1, t0);
            if ($urandom_range(0, 99) < 15)
                add_edge(1'b1, STAMP_W'($urandom));
            add_edge(1'b0, t0 + w);
            if ($urandom_range(0, 99) < 15)
                add_edge(1'b0, STAMP_W'($urandom));
            add_edge(1'b1, t0 + p);
        end
    endtask

    // Wait until every queued request has been taken and every owed
    // measurement has come back. Checked at the rising edge, where neither
    // the driver nor the queue of requests moves.
    task automatic wait_drained();
        begin
            @(posedge clk);
            while (edge_q.size() != 0 || in_valid || meas_q.size() != 0)
                @(posedge clk);
        end
    endtask

    // Sender: holds a request until it is taken, otherwise takes the next
    // pending edge or idles at random.
    always @(negedge clk)
    begin
        if (in_valid && !req_taken)
        begin
            // request still waiting, payload stays put
        end
        else if (edge_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
        begin
            next_req     = edge_q.pop_front();
            edge_rising  <= next_req.rising;
            capture_time <= next_req.stamp;
            in_valid     <= 1'b1;
        end
        else
        begin
            in_valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold on request
    always @(negedge clk)
    begin
        if (long_hold_req && !long_hold_done)
        begin
            hold_left      = HOLD_CYCLES;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Input side: every taken edge goes through the local sequencer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            track_edge({edge_rising, capture_time});
            req_taken = 1'b1;
        end
    end

    // Output side: compare each measurement with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (meas_q.size() == 0)
            begin
                err_count = err_count + 1;
                $display("%0t: unexpected result width=%0d period=%0d duty=%0d err=%0d",
                         $time, high_width, full_period, duty_percent, range_error);
            end
            else if (meas_q[0] !== {high_width, full_period, duty_percent, range_error})
            begin
                err_count = err_count + 1;
                $display("%0t: expected width=%0d period=%0d duty=%0d err=%0d",
                         $time, meas_q[0].width, meas_q[0].period,
                         meas_q[0].duty, meas_q[0].err);
                $display("%0t: actual   width=%0d period=%0d duty=%0d err=%0d",
                         $time, high_width, full_period, duty_percent, range_error);
                void'(meas_q.pop_front());
            end
            else
                void'(meas_q.pop_front());
        end
    end

    // Watchdog on cycles with nothing taken on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("pulse_width_period_duty_capture_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        cap_phase = pwpdc_pkg::PH_START;
        cap_start = '0;
        cap_fall  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: wrong polarity in every phase, zero period, equal width
        // and period, width beyond period, wrap-around, extremes of duty.
        add_edge(1'b0, 16'h1234);
        add_edge(1'b1, 16'h0000);
        add_edge(1'b1, 16'h5555);
        add_edge(1'b0, 16'h0000);
        add_edge(1'b0, 16'hAAAA);
        add_edge(1'b1, 16'h0000);
        add_edge(1'b1, 16'd100);
        add_edge(1'b0, 16'd200);
        add_edge(1'b1, 16'd200);
        add_edge(1'b1, 16'd10);
        add_edge(1'b0, 16'd50);
        add_edge(1'b1, 16'd30);
        add_edge(1'b1, 16'hFFF0);
        add_edge(1'b0, 16'h0005);
        add_edge(1'b1, 16'h0010);
        add_edge(1'b1, 16'h0000);
        add_edge(1'b0, 16'h0000);
        add_edge(1'b1, 16'hFFFF);
        add_edge(1'b1, 16'h0000);
        add_edge(1'b0, 16'hFFFE);
        add_edge(1'b1, 16'hFFFF);
        add_edge(1'b1, 16'hFFFF);
        add_edge(1'b0, 16'hFFFE);
        add_edge(1'b1, 16'hFFFE);
        wait_drained();

        // Random, normal idling on both sides
        while (edge_q.size() < 200)
            add_random_cycle();
        wait_drained();

        // Long stretch with no idling at all
        no_idle = 1'b1;
        while (edge_q.size() < 200)
            add_random_cycle();
        wait_drained();
        no_idle = 1'b0;

        // Receiver holds off while the sender keeps offering, so the result
        // register fills and the input side stalls
        while (edge_q.size() < 150)
            add_random_cycle();
        long_hold_req = 1'b1;
        wait_drained();

        // Tail: random cycles mixed with loose single edges
        while (edge_q.size() < 150)
        begin
            if ($urandom_range(0, 99) < 20)
                add_edge(1'($urandom), STAMP_W'($urandom));
            else
                add_random_cycle();
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("pulse_width_period_duty_capture_unit: match");
        else
            $display("pulse_width_period_duty_capture_unit: mismatch");
        $finish;
    end

endmodule
